@@ design/mbps_pkg.sv @@
// Shared constants, register codes and configuration type for the masked byte
// pattern scanner. No dependencies; every other design file imports this package.
package mbps_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = IDX_W + 1;
  localparam int DATA_W      = 8;
  localparam int ADDR_W      = 48;
  localparam int COUNT_W     = 32;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 6;
  localparam int REG_IDX_W   = 3;

  // register index, taken from paddr[5:3] (8-byte stride)
  typedef enum logic [REG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_CARE_MASK    = 3'd2,
    REG_PATTERN_LEN  = 3'd3,
    REG_SKIP_OVERLAP = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [MAX_PATTERN-1:0][DATA_W-1:0] pattern;
    logic [MAX_PATTERN-1:0]             care_mask;
    logic [LEN_W-1:0]                   pattern_length;
    logic                               skip_overlaps;
  } cfg_t;

  typedef struct packed {
    logic             stage_valid;
    logic [LEN_W-1:0] fill_count;
    logic [LEN_W-1:0] skip_countdown;
  } core_status_t;

endpackage

@@ design/mbps_byte_if.sv @@
// Byte stream channel of the scanner: valid/ready plus one addressed byte.
// Depends on mbps_pkg.
interface mbps_byte_if
  import mbps_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic [ADDR_W-1:0] byte_address;
  logic              region_start;

  modport source (output valid, data_byte, byte_address, region_start, input ready);
  modport sink   (input valid, data_byte, byte_address, region_start, output ready);
endinterface

@@ design/mbps_match_if.sv @@
// Match report channel of the scanner: valid/ready plus address and count.
// Depends on mbps_pkg.
interface mbps_match_if
  import mbps_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  match_address;
  logic [COUNT_W-1:0] match_count;

  modport source (output valid, match_address, match_count, input ready);
  modport sink   (input valid, match_address, match_count, output ready);
endinterface

@@ design/mbps_cfg.sv @@
// APB-style configuration registers of the scanner (64-bit data, 8-byte stride).
// Depends on mbps_pkg.
module mbps_cfg
  import mbps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [CFG_DATA_W-1:0]  pattern_low;
  logic [CFG_DATA_W-1:0]  pattern_high;
  logic [MAX_PATTERN-1:0] care_mask;
  logic [LEN_W-1:0]       pattern_length;
  logic                   skip_overlaps;
  logic                   wr_en;
  reg_idx_t               idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= '0;
      pattern_length <= LEN_W'(1);
      skip_overlaps  <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_PATTERN_LOW:  pattern_low    <= pwdata;
        REG_PATTERN_HIGH: pattern_high   <= pwdata;
        REG_CARE_MASK:    care_mask      <= pwdata[MAX_PATTERN-1:0];
        REG_PATTERN_LEN:  pattern_length <= pwdata[LEN_W-1:0];
        REG_SKIP_OVERLAP: skip_overlaps  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PATTERN_LOW:  prdata = pattern_low;
      REG_PATTERN_HIGH: prdata = pattern_high;
      REG_CARE_MASK:    prdata = CFG_DATA_W'(care_mask);
      REG_PATTERN_LEN:  prdata = CFG_DATA_W'(pattern_length);
      REG_SKIP_OVERLAP: prdata = CFG_DATA_W'(skip_overlaps);
      default:          prdata = '0;
    endcase
  end

  assign cfg.pattern        = {pattern_high, pattern_low};
  assign cfg.care_mask      = care_mask;
  assign cfg.pattern_length = pattern_length;
  assign cfg.skip_overlaps  = skip_overlaps;

endmodule

@@ design/mbps_core.sv @@
// Scan datapath: input register, window shift, masked compare, result register.
// Depends on mbps_pkg, mbps_byte_if and mbps_match_if.
module mbps_core
  import mbps_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  mbps_byte_if.sink    bytes,
  mbps_match_if.source hits,
  output core_status_t status
);

  // input stage
  logic              stage_valid;
  logic [DATA_W-1:0] stage_data;
  logic [ADDR_W-1:0] stage_addr;
  logic              stage_region;

  // scan state
  logic [MAX_PATTERN-1:0][DATA_W-1:0] window;
  logic [MAX_PATTERN-1:0][DATA_W-1:0] window_next;
  logic [LEN_W-1:0]                   fill_count;
  logic [LEN_W-1:0]                   fill_count_next;
  logic [LEN_W-1:0]                   skip_countdown;
  logic [LEN_W-1:0]                   skip_countdown_next;
  logic [COUNT_W-1:0]                 matches_found;
  logic [COUNT_W-1:0]                 matches_found_next;

  // result register
  logic               out_valid;
  logic [ADDR_W-1:0]  out_addr;
  logic [COUNT_W-1:0] out_count;

  logic             advance;
  logic             process;
  logic             hit;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] fill_base;
  logic [LEN_W-1:0] skip_base;

  assign advance     = !out_valid || hits.ready;
  assign process     = advance && stage_valid;
  assign bytes.ready = advance || !stage_valid;

  always_comb begin
    if (cfg.pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (cfg.pattern_length > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = cfg.pattern_length;
    end
  end

  always_comb begin
    logic [LEN_W-1:0] age;
    window_next[0] = stage_data;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      window_next[k] = window[k-1];
    end

    // a region start drops the window fill and any pending skip
    fill_base = stage_region ? '0 : fill_count;
    skip_base = stage_region ? '0 : skip_countdown;
    fill_count_next = (fill_base < LEN_W'(MAX_PATTERN)) ? fill_base + LEN_W'(1) : fill_base;

    // pattern byte j lines up with the byte taken len-1-j items ago
    hit = 1'b1;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      age = len_eff - LEN_W'(1) - LEN_W'(j);
      if ((LEN_W'(j) < len_eff) && cfg.care_mask[j] &&
          (window_next[age[IDX_W-1:0]] != cfg.pattern[j])) begin
        hit = 1'b0;
      end
    end
    if ((skip_base != '0) || (fill_count_next < len_eff)) begin
      hit = 1'b0;
    end

    matches_found_next = matches_found;
    if (hit && (matches_found != '1)) begin
      matches_found_next = matches_found + COUNT_W'(1);
    end

    if (skip_base != '0) begin
      skip_countdown_next = skip_base - LEN_W'(1);
    end else if (hit && cfg.skip_overlaps) begin
      skip_countdown_next = len_eff - LEN_W'(1);
    end else begin
      skip_countdown_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid    <= 1'b0;
      fill_count     <= '0;
      skip_countdown <= '0;
      matches_found  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (bytes.ready) begin
        stage_valid <= bytes.valid;
      end
      if (process) begin
        fill_count     <= fill_count_next;
        skip_countdown <= skip_countdown_next;
        matches_found  <= matches_found_next;
      end
      if (advance) begin
        out_valid <= stage_valid && hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      stage_data   <= bytes.data_byte;
      stage_addr   <= bytes.byte_address;
      stage_region <= bytes.region_start;
    end
    if (process) begin
      window <= window_next;
    end
    if (process && hit) begin
      out_addr  <= stage_addr - ADDR_W'(len_eff - LEN_W'(1));
      out_count <= matches_found_next;
    end
  end

  assign hits.valid         = out_valid;
  assign hits.match_address = out_addr;
  assign hits.match_count   = out_count;

  assign status.stage_valid    = stage_valid;
  assign status.fill_count     = fill_count;
  assign status.skip_countdown = skip_countdown;

endmodule

@@ design/masked_byte_pattern_scanner_top.sv @@
// Masked byte pattern scanner: takes one addressed byte per cycle and reports
// matches of a wildcard pattern of up to 16 bytes. Throughput is one item per
// clock cycle; a byte goes through an input register and then a result
// register before its match is offered. The masked compare over the 16-byte
// window is combinational and lies between those two registers.
// Backpressure on the match channel stalls the input only once both the
// result register and the input register hold work. Configuration goes over
// the APB port at 8-byte stride: pattern bytes 0-7, pattern bytes 8-15, care
// mask, pattern length (0 acts as 1, above 16 as 16) and skip-overlaps; write
// it only while the scanner is idle. Depends on mbps_pkg, the channel
// interfaces, mbps_cfg and mbps_core.
module masked_byte_pattern_scanner_top
  import mbps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  mbps_byte_if.sink             bytes,
  mbps_match_if.source          hits
);

  cfg_t         cfg;
  core_status_t status;

  mbps_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mbps_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .bytes   (bytes),
    .hits    (hits),
    .status  (status)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    status.fill_count <= LEN_W'(MAX_PATTERN))
    else $error("window fill count beyond window size");

  a_skip_bound: assert property (@(posedge clk) disable iff (rst)
    status.skip_countdown < LEN_W'(MAX_PATTERN))
    else $error("skip countdown longer than a pattern");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    (hits.valid && !hits.ready && status.stage_valid) |-> !bytes.ready)
    else $error("input taken while both stages are held");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    hits.valid |-> (hits.match_count != '0))
    else $error("match reported with zero count");

endmodule
